// ===== sv/hscu_pkg.sv =====
package hscu_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int COEF_BITS      = 32;
   localparam int COEF_FRAC_BITS = 30;
   localparam int CSR_INDEX_BITS = 8;

   localparam int HALF_BITS  = COEF_BITS / 2;
   localparam int DIFF_BITS  = VALUE_BITS + 3;
   localparam int PART_BITS  = DIFF_BITS + HALF_BITS + 1;
   localparam int PROD_BITS  = DIFF_BITS + COEF_BITS + 1;
   localparam int SUM_BITS   = PROD_BITS + 2;
   localparam int SHIFT_BITS = SUM_BITS - COEF_FRAC_BITS;
   localparam int TOTAL_BITS = SHIFT_BITS + 1;
   localparam int CDIFF_BITS = VALUE_BITS + 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_X    = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_Y    = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_Z    = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_TIME_STEP = CSR_INDEX_BITS'(3);

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [COEF_BITS-1:0]         coef_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } lane_en_type;

   typedef struct packed {
      logic s4;
      logic s5;
   } merge_en_type;

endpackage

// ===== sv/hscu_lane.sv =====
module hscu_lane (
   input  logic                                  clock,
   input  hscu_pkg::lane_en_type                 en,
   input  hscu_pkg::value_type                   a,
   input  hscu_pkg::value_type                   b,
   input  logic signed [hscu_pkg::CDIFF_BITS-1:0] c,
   input  hscu_pkg::coef_type                    coef,
   output hscu_pkg::prod_type                    prod
);
   import hscu_pkg::*;

   logic signed [DIFF_BITS-1:0] diff_ff, diff_in;
   logic signed [DIFF_BITS-1:0] a_ext, b_ext, c_ext;
   logic signed [PART_BITS-1:0] plo_ff, plo_in, phi_ff, phi_in;
   logic signed [PROD_BITS-1:0] plo_ext, phi_ext;
   prod_type                    prod_ff, prod_in;

   always_comb begin
      a_ext   = DIFF_BITS'(a);
      b_ext   = DIFF_BITS'(b);
      c_ext   = DIFF_BITS'(c);
      diff_in = a_ext + b_ext - c_ext;
   end

   always_comb begin
      plo_in = diff_ff * $signed({1'b0, coef[HALF_BITS-1:0]});
      phi_in = diff_ff * $signed({1'b0, coef[COEF_BITS-1:HALF_BITS]});
   end

   always_comb begin
      plo_ext = PROD_BITS'(plo_ff);
      phi_ext = PROD_BITS'(phi_ff);
      prod_in = (phi_ext <<< HALF_BITS) + plo_ext;
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         diff_ff <= diff_in;
      end
      if (en.s2) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (en.s3) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== sv/hscu_merge.sv =====
module hscu_merge (
   input  logic                   clock,
   input  hscu_pkg::merge_en_type en,
   input  hscu_pkg::prod_type     prod_x,
   input  hscu_pkg::prod_type     prod_y,
   input  hscu_pkg::prod_type     prod_z,
   input  hscu_pkg::prod_type     prod_s,
   input  hscu_pkg::value_type    center,
   input  logic                   on_boundary,
   output hscu_pkg::value_type    new_value,
   output logic                   saturated
);
   import hscu_pkg::*;

   logic signed [SUM_BITS-1:0]   sum_ff, sum_in;
   logic signed [SUM_BITS-1:0]   ex, ey, ez, es, half;
   value_type                    center_ff;
   logic                         boundary_ff;
   logic signed [TOTAL_BITS-1:0] shifted, cen_ext, total, vmax, vmin;
   value_type                    value_ff, value_in;
   logic                         sat_ff, sat_in;

   always_comb begin
      ex     = SUM_BITS'(prod_x);
      ey     = SUM_BITS'(prod_y);
      ez     = SUM_BITS'(prod_z);
      es     = SUM_BITS'(prod_s);
      half   = SUM_BITS'(1) <<< (COEF_FRAC_BITS - 1);
      sum_in = ex + ey + ez + es + half;
   end

   always_comb begin
      shifted = TOTAL_BITS'($signed(sum_ff[SUM_BITS-1:COEF_FRAC_BITS]));
      cen_ext = TOTAL_BITS'(center_ff);
      total   = shifted + cen_ext;
      vmax    = {{(TOTAL_BITS-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
      vmin    = ~vmax;
      if (boundary_ff) begin
         value_in = '0;
         sat_in   = 1'b0;
      end else if (total > vmax) begin
         value_in = vmax[VALUE_BITS-1:0];
         sat_in   = 1'b1;
      end else if (total < vmin) begin
         value_in = vmin[VALUE_BITS-1:0];
         sat_in   = 1'b1;
      end else begin
         value_in = total[VALUE_BITS-1:0];
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s4) begin
         sum_ff      <= sum_in;
         center_ff   <= center;
         boundary_ff <= on_boundary;
      end
      if (en.s5) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign new_value = value_ff;
   assign saturated = sat_ff;

endmodule

// ===== sv/heat_stencil_cell_update_core.sv =====
// One explicit 3D heat/reaction-diffusion update per cell, seven-point stencil.
// Request channel (req_*): centre value, six axis neighbours, source sample and
// boundary flag, all Q16.16 except the flag. A beat is taken when req_valid is
// high and req_stall is low.
// Response channel (rsp_*): updated value (Q16.16) and a saturation flag. A beat
// is taken when rsp_valid is high and rsp_stall is low. Boundary cells give 0.
// Configuration (csr_*): coefficients coef_x/y/z and time_step, unsigned Q2.30,
// written on csr_wr_en at indexes 0..3; other indexes are dropped. Write only
// while no beats are in flight.
// A request beat passes through five registered stages (difference, split
// multiply, product combine, four-lane sum, round and saturate); rsp_valid is
// the valid bit of the last stage. Throughput: one beat per cycle while the
// receiver does not stall.
// When the receiver stalls, the response holds and empty stages still fill, so
// up to five beats are taken before req_stall rises.
// Reset (synchronous, active high) clears the coefficients and empties the pipe.
module heat_stencil_cell_update_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [hscu_pkg::VALUE_BITS-1:0]   req_center,
   input  logic signed [hscu_pkg::VALUE_BITS-1:0]   req_x_plus,
   input  logic signed [hscu_pkg::VALUE_BITS-1:0]   req_x_minus,
   input  logic signed [hscu_pkg::VALUE_BITS-1:0]   req_y_plus,
   input  logic signed [hscu_pkg::VALUE_BITS-1:0]   req_y_minus,
   input  logic signed [hscu_pkg::VALUE_BITS-1:0]   req_z_plus,
   input  logic signed [hscu_pkg::VALUE_BITS-1:0]   req_z_minus,
   input  logic signed [hscu_pkg::VALUE_BITS-1:0]   req_source,
   input  logic                                     req_on_boundary,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [hscu_pkg::VALUE_BITS-1:0]   rsp_new_value,
   output logic                                     rsp_saturated,
   input  logic                                     csr_wr_en,
   input  logic [hscu_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [hscu_pkg::COEF_BITS-1:0]           csr_wr_data
);
   import hscu_pkg::*;

   coef_type coef_x_ff, coef_y_ff, coef_z_ff, time_step_ff;

   logic [5:1] valid_ff, valid_in;
   logic [5:1] load;

   value_type center_ff [1:3];
   logic      boundary_ff [1:3];

   lane_en_type  lane_en;
   merge_en_type merge_en;

   logic signed [CDIFF_BITS-1:0] twice_center, one_center;
   prod_type prod_x, prod_y, prod_z, prod_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_x_ff    <= '0;
         coef_y_ff    <= '0;
         coef_z_ff    <= '0;
         time_step_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_COEF_X:    coef_x_ff    <= csr_wr_data;
            REG_COEF_Y:    coef_y_ff    <= csr_wr_data;
            REG_COEF_Z:    coef_z_ff    <= csr_wr_data;
            REG_TIME_STEP: time_step_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // advance a stage when it is empty or the one after it advances
   always_comb begin
      load[5] = !valid_ff[5] || !rsp_stall;
      for (int k = 4; k >= 1; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in[1] = load[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= 5; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         center_ff[1]   <= req_center;
         boundary_ff[1] <= req_on_boundary;
      end
      for (int k = 2; k <= 3; k++) begin
         if (load[k]) begin
            center_ff[k]   <= center_ff[k-1];
            boundary_ff[k] <= boundary_ff[k-1];
         end
      end
   end

   assign req_stall = !load[1];

   always_comb begin
      lane_en.s1   = load[1];
      lane_en.s2   = load[2];
      lane_en.s3   = load[3];
      merge_en.s4  = load[4];
      merge_en.s5  = load[5];
      one_center   = CDIFF_BITS'(req_center);
      twice_center = one_center <<< 1;
   end

   hscu_lane u_lane_x (
      .clock (clock),
      .en    (lane_en),
      .a     (req_x_plus),
      .b     (req_x_minus),
      .c     (twice_center),
      .coef  (coef_x_ff),
      .prod  (prod_x)
   );

   hscu_lane u_lane_y (
      .clock (clock),
      .en    (lane_en),
      .a     (req_y_plus),
      .b     (req_y_minus),
      .c     (twice_center),
      .coef  (coef_y_ff),
      .prod  (prod_y)
   );

   hscu_lane u_lane_z (
      .clock (clock),
      .en    (lane_en),
      .a     (req_z_plus),
      .b     (req_z_minus),
      .c     (twice_center),
      .coef  (coef_z_ff),
      .prod  (prod_z)
   );

   hscu_lane u_lane_s (
      .clock (clock),
      .en    (lane_en),
      .a     (req_source),
      .b     ('0),
      .c     (one_center),
      .coef  (time_step_ff),
      .prod  (prod_s)
   );

   hscu_merge u_merge (
      .clock       (clock),
      .en          (merge_en),
      .prod_x      (prod_x),
      .prod_y      (prod_y),
      .prod_z      (prod_z),
      .prod_s      (prod_s),
      .center      (center_ff[3]),
      .on_boundary (boundary_ff[3]),
      .new_value   (rsp_new_value),
      .saturated   (rsp_saturated)
   );

   assign rsp_valid = valid_ff[5];

endmodule

// ===== tb/heat_stencil_cell_update_core_test.sv =====
`timescale 1ns / 100ps

module heat_stencil_cell_update_core_test;
   import hscu_pkg::*;

   typedef struct {
      value_type center;
      value_type x_plus;
      value_type x_minus;
      value_type y_plus;
      value_type y_minus;
      value_type z_plus;
      value_type z_minus;
      value_type source;
      logic      on_boundary;
   } stencil_site_type;

   typedef struct {
      value_type new_value;
      logic      saturated;
   } cell_value_type;

   typedef enum logic [1:0] {COEFS_RESET, COEFS_FULL, COEFS_HALF} coef_set_type;

   typedef struct {
      coef_set_type     setting;
      stencil_site_type site;
      logic             typed;
      cell_value_type   want;
   } directed_row_type;

   typedef logic signed [127:0] wide_type;

   localparam value_type VAL_MAX    = 32'sh7FFF_FFFF;
   localparam value_type VAL_MIN    = 32'sh8000_0000;
   localparam wide_type  WIDE_MAX   = 128'sh7FFF_FFFF;
   localparam wide_type  WIDE_MIN   = -128'sh8000_0000;
   localparam wide_type  ROUND_HALF = wide_type'(1) <<< (COEF_FRAC_BITS - 1);
   localparam int        PHASE_ITEMS = 200;
   localparam int        LIMIT_NS    = 2_000_000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   value_type                  req_center = '0;
   value_type                  req_x_plus = '0;
   value_type                  req_x_minus = '0;
   value_type                  req_y_plus = '0;
   value_type                  req_y_minus = '0;
   value_type                  req_z_plus = '0;
   value_type                  req_z_minus = '0;
   value_type                  req_source = '0;
   logic                       req_on_boundary = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   value_type                  rsp_new_value;
   logic                       rsp_saturated;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [COEF_BITS-1:0]       csr_wr_data = '0;

   coef_type       grid_cx = '0;
   coef_type       grid_cy = '0;
   coef_type       grid_cz = '0;
   coef_type       grid_dt = '0;
   cell_value_type expected_values[$];
   int             errors = 0;
   int             cells_sent = 0;
   int             boundary_sent = 0;
   int             clipped_seen = 0;
   int             settings_used = 0;
   bit             rsp_idle_on = 1'b1;
   bit             rsp_long_hold = 1'b0;

   heat_stencil_cell_update_core dut (.*);

   always #2 clock = ~clock;

   function automatic wide_type second_diff(value_type plus, value_type minus,
                                            value_type mid);
      wide_type a, b, c;
      a = plus;
      b = minus;
      c = mid;
      return a + b - c - c;
   endfunction

   function automatic wide_type weigh(wide_type d, coef_type k);
      wide_type kk;
      kk = {96'd0, k};
      return d * kk;
   endfunction

   function automatic cell_value_type next_cell_value(stencil_site_type s);
      cell_value_type r;
      wide_type       p, src, acc, tot;
      r.new_value = '0;
      r.saturated = 1'b0;
      if (s.on_boundary) return r;
      p   = s.center;
      src = s.source;
      acc = weigh(second_diff(s.x_plus, s.x_minus, s.center), grid_cx)
          + weigh(second_diff(s.y_plus, s.y_minus, s.center), grid_cy)
          + weigh(second_diff(s.z_plus, s.z_minus, s.center), grid_cz)
          + weigh(src - p, grid_dt);
      acc = (acc + ROUND_HALF) >>> COEF_FRAC_BITS;
      tot = acc + p;
      if (tot > WIDE_MAX) begin
         r.new_value = VAL_MAX;
         r.saturated = 1'b1;
      end else if (tot < WIDE_MIN) begin
         r.new_value = VAL_MIN;
         r.saturated = 1'b1;
      end else begin
         r.new_value = tot[VALUE_BITS-1:0];
      end
      return r;
   endfunction

   function automatic void store_reg(logic [CSR_INDEX_BITS-1:0] idx, coef_type d);
      case (idx)
         REG_COEF_X:    grid_cx = d;
         REG_COEF_Y:    grid_cy = d;
         REG_COEF_Z:    grid_cz = d;
         REG_TIME_STEP: grid_dt = d;
         default: ;
      endcase
   endfunction

   function automatic int draw_gap(bit on);
      if (!on || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 15);
   endfunction

   function automatic value_type pick_extreme();
      case ($urandom_range(0, 5))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return '0;
         3: return -1;
         4: return 1;
         default: return $urandom;
      endcase
   endfunction

   function automatic value_type field_value(int kind, value_type c);
      if (kind < 4) return c + value_type'($urandom_range(0, 262143)) - value_type'(131072);
      if (kind < 6) return $urandom;
      return pick_extreme();
   endfunction

   function automatic stencil_site_type random_site();
      stencil_site_type s;
      int               kind;
      kind          = $urandom_range(0, 7);
      s.center      = (kind >= 6) ? pick_extreme() : value_type'($urandom);
      s.x_plus      = field_value(kind, s.center);
      s.x_minus     = field_value(kind, s.center);
      s.y_plus      = field_value(kind, s.center);
      s.y_minus     = field_value(kind, s.center);
      s.z_plus      = field_value(kind, s.center);
      s.z_minus     = field_value(kind, s.center);
      s.source      = field_value(kind, s.center);
      s.on_boundary = ($urandom_range(0, 7) == 0);
      return s;
   endfunction

   function automatic directed_row_type drow(coef_set_type st, value_type c,
                                             value_type xp, value_type xm,
                                             value_type yp, value_type ym,
                                             value_type zp, value_type zm,
                                             value_type src, logic b,
                                             logic typed, value_type wv, logic ws);
      directed_row_type r;
      r.setting            = st;
      r.site.center        = c;
      r.site.x_plus        = xp;
      r.site.x_minus       = xm;
      r.site.y_plus        = yp;
      r.site.y_minus       = ym;
      r.site.z_plus        = zp;
      r.site.z_minus       = zm;
      r.site.source        = src;
      r.site.on_boundary   = b;
      r.typed              = typed;
      r.want.new_value     = wv;
      r.want.saturated     = ws;
      return r;
   endfunction

   task automatic put_reg(logic [CSR_INDEX_BITS-1:0] idx, coef_type d);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = d;
      store_reg(idx, d);
   endtask

   task automatic write_coefs(coef_type cx, coef_type cy, coef_type cz, coef_type dt);
      put_reg(REG_COEF_X, cx);
      put_reg(REG_COEF_Y, cy);
      put_reg(REG_COEF_Z, cz);
      put_reg(REG_TIME_STEP, dt);
      put_reg(CSR_INDEX_BITS'($urandom_range(4, 255)), $urandom);
      @(negedge clock);
      csr_wr_en = 1'b0;
      settings_used++;
   endtask

   // drop valid, wait out every pending beat, then idle before returning
   task automatic settle();
      req_valid = 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic offer(stencil_site_type s, int gap, logic typed, cell_value_type want);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_center      = s.center;
      req_x_plus      = s.x_plus;
      req_x_minus     = s.x_minus;
      req_y_plus      = s.y_plus;
      req_y_minus     = s.y_minus;
      req_z_plus      = s.z_plus;
      req_z_minus     = s.z_minus;
      req_source      = s.source;
      req_on_boundary = s.on_boundary;
      req_valid       = 1'b1;
      do @(posedge clock); while (req_stall);
      expected_values.push_back(typed ? want : next_cell_value(s));
      cells_sent++;
      if (s.on_boundary) boundary_sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      cell_value_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_saturated) clipped_seen++;
         if (expected_values.size() == 0) begin
            $display("%0t: response beat with nothing pending, new_value %h saturated %b",
                     $time, rsp_new_value, rsp_saturated);
            errors++;
         end else begin
            w = expected_values.pop_front();
            if (rsp_new_value !== w.new_value) begin
               $display("%0t: new_value expected %h got %h", $time, w.new_value,
                        rsp_new_value);
               errors++;
            end
            if (rsp_saturated !== w.saturated) begin
               $display("%0t: saturated expected %b got %b", $time, w.saturated,
                        rsp_saturated);
               errors++;
            end
         end
      end
   end

   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_long_hold) begin
            rsp_long_hold = 1'b0;
            rsp_stall = 1'b1;
            repeat (80) @(negedge clock);
         end
         gap = draw_gap(rsp_idle_on);
         if (gap > 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("timeout with %0d beats pending", expected_values.size());
      $display("heat_stencil_cell_update_core_test NOT OK");
      $finish;
   end

   initial begin
      directed_row_type rows[$];
      coef_set_type     cur_set;
      cell_value_type   none;
      none.new_value = '0;
      none.saturated = 1'b0;

      repeat (12) @(negedge clock);
      reset = 1'b0;

      // coefficients at reset: the cell passes through unchanged, boundary cells give 0
      rows.push_back(drow(COEFS_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      rows.push_back(drow(COEFS_RESET, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
                          VAL_MIN, VAL_MIN, VAL_MIN, 0, 1, VAL_MAX, 0));
      rows.push_back(drow(COEFS_RESET, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
                          VAL_MAX, VAL_MAX, VAL_MAX, 0, 1, VAL_MIN, 0));
      rows.push_back(drow(COEFS_RESET, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
                          VAL_MAX, VAL_MAX, VAL_MAX, 0, 1, VAL_MAX, 0));
      rows.push_back(drow(COEFS_RESET, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
                          VAL_MIN, VAL_MIN, VAL_MIN, 0, 1, VAL_MIN, 0));
      rows.push_back(drow(COEFS_RESET, 32'sh0001_0000, 32'sh0002_0000, 32'sh0002_0000,
                          32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000,
                          32'sh0003_0000, 0, 1, 32'sh0001_0000, 0));
      rows.push_back(drow(COEFS_RESET, -1, 32'sh5A5A_5A5A, 32'shA5A5_A5A5, 32'sh0F0F_0F0F,
                          32'shF0F0_F0F0, 32'sh3333_3333, 32'shCCCC_CCCC, 32'sh7777_7777,
                          0, 1, -1, 0));
      rows.push_back(drow(COEFS_RESET, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
                          VAL_MIN, VAL_MIN, VAL_MIN, 1, 1, 0, 0));
      rows.push_back(drow(COEFS_RESET, 32'shA5A5_A5A5, -1, -1, -1, -1, -1, -1, -1,
                          1, 1, 0, 0));
      // coefficients all ones: clipping at both ends, plus boundary, flat and model-checked cells
      rows.push_back(drow(COEFS_FULL, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
                          VAL_MIN, VAL_MIN, VAL_MIN, 0, 1, VAL_MIN, 1));
      rows.push_back(drow(COEFS_FULL, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
                          VAL_MAX, VAL_MAX, VAL_MAX, 0, 1, VAL_MAX, 1));
      rows.push_back(drow(COEFS_FULL, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
                          VAL_MIN, VAL_MIN, VAL_MIN, 1, 1, 0, 0));
      rows.push_back(drow(COEFS_FULL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      rows.push_back(drow(COEFS_FULL, 32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678,
                          32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678,
                          32'sh1234_5678, 0, 1, 32'sh1234_5678, 0));
      rows.push_back(drow(COEFS_FULL, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(drow(COEFS_FULL, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(drow(COEFS_FULL, 32'sh0001_0000, 32'sh0001_8000, 32'sh0000_8000,
                          32'sh0002_0000, 0, -65536, 32'sh0003_0000, 32'sh0010_0000,
                          0, 0, 0, 0));
      rows.push_back(drow(COEFS_FULL, 32'sh7FFF_0000, VAL_MAX, 32'sh7FFF_0000,
                          32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh7FFF_0000, 32'sh7FFF_0000,
                          32'sh7FFF_0000, 0, 0, 0, 0));
      // coefficients one half: rounding ties on both signs
      rows.push_back(drow(COEFS_HALF, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(drow(COEFS_HALF, 0, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      rows.push_back(drow(COEFS_HALF, 3, 0, 0, 0, 0, 0, 0, 4, 0, 0, 0, 0));
      rows.push_back(drow(COEFS_HALF, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
                          VAL_MAX, VAL_MAX, VAL_MIN, 0, 0, 0, 0));
      rows.push_back(drow(COEFS_HALF, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
                          VAL_MIN, VAL_MIN, VAL_MAX, 0, 0, 0, 0));

      cur_set = COEFS_RESET;
      foreach (rows[i]) begin
         if (rows[i].setting != cur_set) begin
            settle();
            case (rows[i].setting)
               COEFS_FULL: write_coefs('1, '1, '1, '1);
               COEFS_HALF: write_coefs(32'h2000_0000, 32'h2000_0000, 32'h2000_0000,
                                       32'h2000_0000);
               default:    write_coefs('0, '0, '0, '0);
            endcase
            cur_set = rows[i].setting;
         end
         offer(rows[i].site, draw_gap(1'b1), rows[i].typed, rows[i].want);
      end

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            0: write_coefs($urandom_range(0, 32'h0AAA_AAAA), $urandom_range(0, 32'h0AAA_AAAA),
                           $urandom_range(0, 32'h0AAA_AAAA), $urandom_range(0, 32'h0AAA_AAAA));
            1: write_coefs($urandom, $urandom, $urandom, $urandom);
            2: write_coefs('1, '1, '1, '1);
            3: write_coefs('0, '0, '0, $urandom);
            4: write_coefs(32'h1 << $urandom_range(0, 31), 32'h1 << $urandom_range(0, 31),
                           32'h1 << $urandom_range(0, 31), 32'h1 << $urandom_range(0, 31));
            default: write_coefs('0, '0, '0, '0);
         endcase
         rsp_idle_on = (ph != 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 1 && n == 40) rsp_long_hold = 1'b1;
            if (ph == 2 && n == PHASE_ITEMS / 2) settle();
            offer(random_site(), draw_gap(ph != 1), 1'b0, none);
         end
      end

      settle();
      repeat (20) @(posedge clock);
      $display("covered %0d cells (%0d boundary, %0d clipped results)", cells_sent,
               boundary_sent, clipped_seen);
      $display("over %0d coefficient settings with random idling and a long receiver hold",
               settings_used);
      if (errors == 0) begin
         $display("heat_stencil_cell_update_core_test OK");
      end else begin
         $display("heat_stencil_cell_update_core_test NOT OK");
      end
      $finish;
   end

endmodule
